@@ rtl/core/quadrature_capture_speed_direction_macros.svh @@
// Assertion macros used by the quadrature capture RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef QUADRATURE_CAPTURE_SPEED_DIRECTION_MACROS_SVH
`define QUADRATURE_CAPTURE_SPEED_DIRECTION_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define QCSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QCSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/qcsd_pkg.sv @@
// Shared types, codes and width helpers for the quadrature capture block.
// No dependencies.
package qcsd_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic PHASE_A = 1'b0;
    localparam logic PHASE_B = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic        operation;
        logic        motor;
        logic        phase;
        logic [15:0] capture_value;
    } t_item;

    typedef struct packed {
        logic        updated;
        logic        clear_counter;
        logic [15:0] speed_count;
        logic        direction;
        logic [14:0] half_cycle;
        logic [15:0] phase_offset;
    } t_result;

    function automatic t_count to_count(logic [15:0] v);
        logic [COUNT_WIDTH+15:0] w;
        w = {{COUNT_WIDTH{1'b0}}, v};
        return w[COUNT_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] to_16(t_count c);
        logic [COUNT_WIDTH+15:0] w;
        w = {16'b0, c};
        return w[15:0];
    endfunction

    function automatic logic [14:0] to_15(t_count c);
        logic [COUNT_WIDTH+15:0] w;
        w = {16'b0, c};
        return w[14:0];
    endfunction

endpackage

@@ rtl/core/qcsd_input_stage.sv @@
// Input register for capture and timeout items.
// Depends on qcsd_pkg.
module qcsd_input_stage
    import qcsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/core/qcsd_motor_state.sv @@
// Per-motor arming, stamp pairing and period/direction computation.
// Depends on qcsd_pkg and the assertion macro header.
`include "quadrature_capture_speed_direction_macros.svh"

module qcsd_motor_state
    import qcsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic [1:0]      r_armed,   n_armed;
    logic [1:0][1:0] r_pending, n_pending;
    logic [1:0][1:0] r_pair,    n_pair;
    t_count          r_start [2][2];
    t_count          n_start [2][2];
    t_count          r_end   [2][2];
    t_count          n_end   [2][2];
    t_count          r_speed [2];
    t_count          n_speed [2];
    logic [1:0]      r_dir,     n_dir;
    t_count          r_half  [2];
    t_count          n_half  [2];
    t_count          r_offset[2];
    t_count          n_offset[2];

    logic   m;
    logic   p;
    logic   p_other;
    t_count v;
    t_count s_a, s_b, e_a, e_b;
    t_count period, half, diff;
    logic   dir;
    logic   calc_ok;
    logic   upd, clr;

    assign m       = i_item.motor;
    assign p       = i_item.phase;
    assign p_other = ~i_item.phase;
    assign v       = to_count(i_item.capture_value);

    // the edge being handled supplies the end stamp of its own phase
    always_comb begin
        s_a = r_start[m][PHASE_A];
        s_b = r_start[m][PHASE_B];
        e_a = (p == PHASE_A) ? v : r_end[m][PHASE_A];
        e_b = (p == PHASE_B) ? v : r_end[m][PHASE_B];
        calc_ok = !(e_a < s_a) && !(e_b < s_b);
        period  = e_a - s_a;
        half    = period >> 1;
        if (s_b > s_a) begin
            diff = s_b - s_a;
            dir  = diff > half;
        end else begin
            diff = s_a - s_b;
            dir  = !(diff > half);
        end
    end

    always_comb begin
        n_armed   = r_armed;
        n_pending = r_pending;
        n_pair    = r_pair;
        n_start   = r_start;
        n_end     = r_end;
        n_speed   = r_speed;
        n_dir     = r_dir;
        n_half    = r_half;
        n_offset  = r_offset;
        upd       = 1'b0;
        clr       = 1'b0;
        if (i_fire) begin
            if (i_item.operation == OP_TIMEOUT) begin
                n_speed[m] = '0;
                n_armed[m] = 1'b0;
            end else if (!r_armed[m]) begin
                n_armed[m] = 1'b1;
                clr        = 1'b1;
            end else if (!r_pending[m][p]) begin
                n_start[m][p]   = v;
                n_pending[m][p] = 1'b1;
            end else begin
                n_end[m][p]     = v;
                n_pending[m][p] = 1'b0;
                if (r_pair[m][p_other]) begin
                    clr                = 1'b1;
                    n_pair[m][p_other] = 1'b0;
                    if (calc_ok) begin
                        upd         = 1'b1;
                        n_speed[m]  = period;
                        n_dir[m]    = dir;
                        n_half[m]   = half;
                        n_offset[m] = diff;
                    end
                end else begin
                    n_pair[m][p] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_result.updated       = upd;
        o_result.clear_counter = clr;
        o_result.speed_count   = to_16(n_speed[m]);
        o_result.direction     = n_dir[m];
        o_result.half_cycle    = to_15(n_half[m]);
        o_result.phase_offset  = to_16(n_offset[m]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= '0;
            r_pending <= '0;
            r_pair    <= '0;
            r_start   <= '{default: '0};
            r_end     <= '{default: '0};
            r_speed   <= '{default: '0};
            r_dir     <= '0;
            r_half    <= '{default: '0};
            r_offset  <= '{default: '0};
        end else begin
            r_armed   <= n_armed;
            r_pending <= n_pending;
            r_pair    <= n_pair;
            r_start   <= n_start;
            r_end     <= n_end;
            r_speed   <= n_speed;
            r_dir     <= n_dir;
            r_half    <= n_half;
            r_offset  <= n_offset;
        end
    end

    `QCSD_ASSERT_SAME(a_upd_clears, i_fire && upd, clr, "update without counter clear")
    `QCSD_ASSERT_SAME(a_timeout_quiet, i_fire && i_item.operation == OP_TIMEOUT,
        !upd && !clr && o_result.speed_count == 16'd0, "timeout result wrong")
    `QCSD_ASSERT_NEXT(a_timeout_disarms, i_fire && i_item.operation == OP_TIMEOUT,
        r_armed == ($past(r_armed) & ~(2'b01 << $past(i_item.motor))),
        "timeout did not disarm only its motor")
    `QCSD_ASSERT_SAME(a_arm_only, i_fire && i_item.operation == OP_CAPTURE && !r_armed[m],
        clr && !upd, "arming capture handled wrong")

endmodule

@@ rtl/core/qcsd_output_stage.sv @@
// Result register with stall handling toward the receiver.
// Depends on qcsd_pkg.
module qcsd_output_stage
    import qcsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_take,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_take = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/core/quadrature_capture_speed_direction.sv @@
// Two-motor quadrature capture: period, phase offset and direction per motor.
// Depends on qcsd_pkg, qcsd_input_stage, qcsd_motor_state, qcsd_output_stage.
//
// Input channel (i_in_valid / o_in_stall) carries one event item: a capture
// edge (motor, phase, timer value) or a speed timeout for a motor. Output
// channel (o_out_valid / i_out_stall) returns exactly one result item per
// event: updated and clear_counter flags plus the stored speed, direction,
// half period and phase offset of the addressed motor after the event.
// Each accepted item is registered in the input register, then one pass of
// compare/subtract logic updates motor state and loads the result register
// that drives o_out_valid. Throughput is one item per cycle, limited only
// by the result register being drained.
// Synchronous active-low reset clears all motor state to zero and empties
// both registers. When the receiver stalls, the result holds and one more
// item may wait in the input register; further items see o_in_stall high.
module quadrature_capture_speed_direction
    import qcsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic        i_motor,
    input  logic        i_phase,
    input  logic [15:0] i_capture_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_updated,
    output logic        o_clear_counter,
    output logic [15:0] o_speed_count,
    output logic        o_direction,
    output logic [14:0] o_half_cycle,
    output logic [15:0] o_phase_offset
);

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    take;
    t_result next_result;
    t_result out_result;

    always_comb begin
        in_item.operation     = i_operation;
        in_item.motor         = i_motor;
        in_item.phase         = i_phase;
        in_item.capture_value = i_capture_value;
    end

    qcsd_input_stage u_input (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (take),
        .o_stall (o_in_stall),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    qcsd_motor_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (stage_valid && take),
        .i_item   (stage_item),
        .o_result (next_result)
    );

    qcsd_output_stage u_output (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .i_result (next_result),
        .i_stall  (i_out_stall),
        .o_take   (take),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_updated       = out_result.updated;
    assign o_clear_counter = out_result.clear_counter;
    assign o_speed_count   = out_result.speed_count;
    assign o_direction     = out_result.direction;
    assign o_half_cycle    = out_result.half_cycle;
    assign o_phase_offset  = out_result.phase_offset;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for quadrature_capture_speed_direction: a directed
// part and random capture sequences, checked against an in-bench predictor.
// Depends on qcsd_pkg and the quadrature_capture_speed_direction RTL.
module tb_top;
    import qcsd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_operation = OP_CAPTURE;
    logic        i_motor = 1'b0;
    logic        i_phase = PHASE_A;
    logic [15:0] i_capture_value = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_updated;
    logic        o_clear_counter;
    logic [15:0] o_speed_count;
    logic        o_direction;
    logic [14:0] o_half_cycle;
    logic [15:0] o_phase_offset;

    quadrature_capture_speed_direction u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_motor         (i_motor),
        .i_phase         (i_phase),
        .i_capture_value (i_capture_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_updated       (o_updated),
        .o_clear_counter (o_clear_counter),
        .o_speed_count   (o_speed_count),
        .o_direction     (o_direction),
        .o_half_cycle    (o_half_cycle),
        .o_phase_offset  (o_phase_offset)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_item   pending_events[$];
    t_result due_results[$];
    int      offered_count = 0;
    int      accepted_count = 0;
    int      error_count = 0;
    int      hold_cycles = 0;
    bit      hold_done = 1'b0;
    logic    calm;

    // predictor state, indexed by motor or {motor, phase}
    logic        armed_m    [2] = '{default: '0};
    logic        start_pend [4] = '{default: '0};
    logic        pair_ready [4] = '{default: '0};
    t_count      start_ts   [4] = '{default: '0};
    t_count      stop_ts    [4] = '{default: '0};
    t_count      speed_m    [2] = '{default: '0};
    logic        dir_m      [2] = '{default: '0};
    logic [14:0] half_m     [2] = '{default: '0};
    t_count      offset_m   [2] = '{default: '0};

    assign calm = (accepted_count >= 800) && (accepted_count < 1100);

    function automatic t_result predict_event(t_item it);
        t_result    r;
        t_count     v, s1, e1, s2, e2, per, diff;
        logic [1:0] idx, oth;
        logic       m;
        r   = '0;
        m   = it.motor;
        v   = t_count'(it.capture_value);
        idx = {m, it.phase};
        oth = {m, ~it.phase};
        if (it.operation == OP_TIMEOUT) begin
            speed_m[m] = '0;
            armed_m[m] = 1'b0;
        end else if (!armed_m[m]) begin
            armed_m[m] = 1'b1;
            r.clear_counter = 1'b1;
        end else if (!start_pend[idx]) begin
            start_ts[idx] = v;
            start_pend[idx] = 1'b1;
        end else begin
            stop_ts[idx] = v;
            start_pend[idx] = 1'b0;
            if (pair_ready[oth]) begin
                r.clear_counter = 1'b1;
                pair_ready[oth] = 1'b0;
                s1 = start_ts[{m, PHASE_A}];
                e1 = stop_ts[{m, PHASE_A}];
                s2 = start_ts[{m, PHASE_B}];
                e2 = stop_ts[{m, PHASE_B}];
                if (!(e1 < s1 || e2 < s2)) begin
                    per = e1 - s1;
                    if (s2 > s1) begin
                        diff = s2 - s1;
                        dir_m[m] = diff > (per >> 1);
                    end else begin
                        diff = s1 - s2;
                        dir_m[m] = !(diff > (per >> 1));
                    end
                    speed_m[m]  = per;
                    half_m[m]   = 15'(per >> 1);
                    offset_m[m] = diff;
                    r.updated   = 1'b1;
                end
            end else begin
                pair_ready[idx] = 1'b1;
            end
        end
        r.speed_count  = 16'(speed_m[m]);
        r.direction    = dir_m[m];
        r.half_cycle   = half_m[m];
        r.phase_offset = 16'(offset_m[m]);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned seen);
        if (want !== seen) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            error_count++;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && accepted_count != offered_count)) begin
            if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
                it = pending_events.pop_front();
                offered_count++;
                i_in_valid      <= 1'b1;
                i_operation     <= it.operation;
                i_motor         <= it.motor;
                i_phase         <= it.phase;
                i_capture_value <= it.capture_value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && accepted_count >= 400) begin
            hold_done = 1'b1;
            hold_cycles = 60;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_item   it;
        t_result got, want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                it = '{i_operation, i_motor, i_phase, i_capture_value};
                due_results.push_back(predict_event(it));
                accepted_count++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_updated, o_clear_counter, o_speed_count, o_direction,
                        o_half_cycle, o_phase_offset};
                if (due_results.size() == 0) begin
                    $error("result item with none expected");
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("updated", want.updated, got.updated);
                    check_field("clear_counter", want.clear_counter, got.clear_counter);
                    check_field("speed_count", want.speed_count, got.speed_count);
                    check_field("direction", want.direction, got.direction);
                    check_field("half_cycle", want.half_cycle, got.half_cycle);
                    check_field("phase_offset", want.phase_offset, got.phase_offset);
                end
            end
        end
    end

    task automatic push_item(logic op, logic m, logic ph, logic [15:0] val);
        pending_events.push_back('{op, m, ph, val});
    endtask

    task automatic push_pairs(logic m, logic [15:0] s1, logic [15:0] s2,
                              logic [15:0] e1, logic [15:0] e2, int order);
        case (order)
            0: begin
                push_item(OP_CAPTURE, m, PHASE_A, s1);
                push_item(OP_CAPTURE, m, PHASE_B, s2);
                push_item(OP_CAPTURE, m, PHASE_A, e1);
                push_item(OP_CAPTURE, m, PHASE_B, e2);
            end
            1: begin
                push_item(OP_CAPTURE, m, PHASE_B, s2);
                push_item(OP_CAPTURE, m, PHASE_A, s1);
                push_item(OP_CAPTURE, m, PHASE_B, e2);
                push_item(OP_CAPTURE, m, PHASE_A, e1);
            end
            2: begin
                push_item(OP_CAPTURE, m, PHASE_A, s1);
                push_item(OP_CAPTURE, m, PHASE_A, e1);
                push_item(OP_CAPTURE, m, PHASE_B, s2);
                push_item(OP_CAPTURE, m, PHASE_B, e2);
            end
            default: begin
                push_item(OP_CAPTURE, m, PHASE_B, s2);
                push_item(OP_CAPTURE, m, PHASE_B, e2);
                push_item(OP_CAPTURE, m, PHASE_A, s1);
                push_item(OP_CAPTURE, m, PHASE_A, e1);
            end
        endcase
    endtask

    // one measurement cycle with random content; sometimes reversed stamps
    task automatic gen_measurement();
        logic        m;
        logic [15:0] s1, e1, s2, e2, t;
        int unsigned per, off;
        m = 1'($urandom_range(1));
        if ($urandom_range(19) == 0) begin
            push_item(OP_TIMEOUT, m, 1'($urandom_range(1)), 16'($urandom));
            push_item(OP_CAPTURE, m, 1'($urandom_range(1)), 16'($urandom));
        end
        per = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2000);
        s1  = 16'($urandom_range(65535 - per));
        e1  = 16'(s1 + per);
        if ($urandom_range(1)) begin
            s2 = 16'($urandom);
        end else begin
            off = $urandom_range(per);
            s2 = $urandom_range(1) ? 16'(s1 - off) : 16'(s1 + off);
        end
        e2 = 16'($urandom_range(65535, s2));
        if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) begin
                t = s1; s1 = e1; e1 = t;
            end else begin
                t = s2; s2 = e2; e2 = t;
            end
        end
        push_pairs(m, s1, s2, e1, e2, $urandom_range(3));
    endtask

    initial begin
        int n;
        // directed: arming, both direction branches, extremes, reversed, timeout
        push_item(OP_CAPTURE, 1'b0, PHASE_A, 16'hFFFF);
        push_item(OP_CAPTURE, 1'b1, PHASE_B, 16'h0000);
        push_pairs(1'b0, 16'd100, 16'd150, 16'd300, 16'd350, 0);
        push_pairs(1'b0, 16'd1000, 16'd1180, 16'd1200, 16'd1400, 0);
        push_pairs(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 0);
        push_pairs(1'b0, 16'd600, 16'd400, 16'd800, 16'd900, 0);
        push_pairs(1'b1, 16'd5000, 16'd5100, 16'd4000, 16'd6000, 0);
        push_item(OP_TIMEOUT, 1'b0, PHASE_A, 16'h0000);
        push_item(OP_CAPTURE, 1'b0, PHASE_B, 16'h1234);
        push_item(OP_TIMEOUT, 1'b1, PHASE_B, 16'hFFFF);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender pauses until the directed part has fully drained
        @(negedge i_clk);
        while (pending_events.size() != 0 || offered_count != accepted_count
               || due_results.size() != 0)
            @(negedge i_clk);

        n = 0;
        while (n < 1500) begin
            if ($urandom_range(99) < 80) begin
                gen_measurement();
            end else begin
                push_item(($urandom_range(5) == 0) ? OP_TIMEOUT : OP_CAPTURE,
                          1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
            end
            n = pending_events.size();
        end

        while (pending_events.size() != 0 || offered_count != accepted_count
               || due_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && due_results.size() == 0) begin
            $display("quadrature_capture_speed_direction verification clean");
        end else begin
            $display("quadrature_capture_speed_direction verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("quadrature_capture_speed_direction verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/qcsd_pkg.sv
rtl/core/qcsd_input_stage.sv
rtl/core/qcsd_motor_state.sv
rtl/core/qcsd_output_stage.sv
rtl/core/quadrature_capture_speed_direction.sv
tb/tb_top.sv
